### hdl/rtbl_pkg.sv
// Shared types and constants for the request token bucket limiter.
package rtbl_pkg;

    localparam int unsigned LevelW   = 32;
    localparam int unsigned RateW    = 24;
    localparam int unsigned BurstW   = 16;
    localparam int unsigned RunW     = 17;
    localparam int unsigned TicksW   = 32;
    localparam int unsigned CfgDataW = 24;
    localparam int unsigned CfgIdxW  = 2;

    localparam logic [LevelW-1:0] ONE_TOKEN = 32'h0001_0000;
    localparam logic [RunW-1:0]   RUN_MAX   = 17'h1_0000;

    localparam logic [CfgIdxW-1:0] REG_LIMIT_ENABLE     = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_RATE_PER_TICK    = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_BURST_TOKENS     = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_DISCONNECT_AFTER = 2'd3;

    localparam logic [1:0] VERDICT_GRANT      = 2'd0;
    localparam logic [1:0] VERDICT_GRANT_WAIT = 2'd1;
    localparam logic [1:0] VERDICT_DISCONNECT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CHECK,
        S_DIV,
        S_FIN,
        S_DONE
    } t_state;

endpackage

### hdl/request_token_bucket_limiter.sv
// Request token bucket limiter: sequencer around one shared adder/subtractor.
//
// Each request takes one transfer in, then with policing enabled a bit-serial
// refill multiply (elapsed ticks times rate, one tick bit a cycle), a bucket
// update and verdict step, and for a delayed request a restoring division of
// the token deficit by the rate plus a finishing step; a final step moves the
// result to the output register once that register is free. With policing
// disabled a request goes straight to the final step. The multiply, update,
// division and finishing steps share a single 35-bit adder. The input
// side is ready only while the sequencer is idle; a finished result waits in
// the output register until it is taken, and the next request is accepted
// meanwhile. Configuration writes take effect at once and are meant for idle.
module request_token_bucket_limiter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_elapsed_ticks,
    input  logic        i_new_connection,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_verdict,
    output logic [31:0] o_wait_ticks,
    output logic [16:0] o_delay_run,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    rtbl_pkg::t_state r_state, n_state;

    logic        r_en;
    logic [23:0] r_rate;
    logic [15:0] r_burst;
    logic [15:0] r_disc;

    logic [31:0] r_level, n_level;
    logic [16:0] r_run, n_run;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_opa, n_opa;
    logic [32:0] r_acc, n_acc;
    logic [23:0] r_rem, n_rem;
    logic [1:0]  r_pverdict, n_pverdict;
    logic [31:0] r_pwait, n_pwait;

    logic        r_ov, n_ov;
    logic [1:0]  r_overdict, n_overdict;
    logic [31:0] r_owait, n_owait;
    logic [16:0] r_orun, n_orun;

    logic [23:0] rate_eff;
    logic [15:0] burst_eff;
    logic [31:0] cap;
    logic [31:0] cap_m1;
    logic [33:0] add_a, add_b;
    logic        add_cin;
    logic [34:0] add_sum;
    logic [31:0] lvl;
    logic [16:0] run_inc;
    logic [31:0] fin_lvl;
    logic [31:0] rmr;
    logic        accept;

    assign rate_eff  = (r_rate == 24'd0) ? 24'd1 : r_rate;
    assign burst_eff = (r_burst == 16'd0) ? 16'd1 : r_burst;
    assign cap       = {burst_eff, 16'h0000};
    assign cap_m1    = {burst_eff - 16'd1, 16'h0000};
    assign accept    = i_valid && o_ready;

    assign o_ready      = (r_state == rtbl_pkg::S_IDLE);
    assign o_valid      = r_ov;
    assign o_verdict    = r_overdict;
    assign o_wait_ticks = r_owait;
    assign o_delay_run  = r_orun;

    // shared adder operand select
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        unique case (r_state)
            rtbl_pkg::S_MUL: begin
                add_a = {r_acc, 1'b0};
                add_b = r_opa[31] ? {10'd0, rate_eff} : 34'd0;
            end
            rtbl_pkg::S_CHECK: begin
                add_a = {2'd0, r_level};
                add_b = {1'b0, r_acc};
            end
            rtbl_pkg::S_DIV: begin
                add_a   = {9'd0, r_rem, r_opa[16]};
                add_b   = ~{10'd0, rate_eff};
                add_cin = 1'b1;
            end
            rtbl_pkg::S_FIN: begin
                add_a   = {10'd0, rate_eff};
                add_b   = ~{10'd0, r_rem};
                add_cin = 1'b1;
            end
            default: begin
                add_a   = '0;
                add_b   = '0;
                add_cin = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {34'd0, add_cin};

    assign lvl     = (add_sum[33:0] > {2'd0, cap}) ? cap : add_sum[31:0];
    assign run_inc = (r_run == rtbl_pkg::RUN_MAX) ? r_run : r_run + 17'd1;
    assign rmr     = {8'd0, add_sum[23:0]};
    assign fin_lvl = (r_rem == 24'd0) ? 32'd0 : ((rmr > cap_m1) ? cap_m1 : rmr);

    always_comb begin
        n_state    = r_state;
        n_level    = r_level;
        n_run      = r_run;
        n_cnt      = r_cnt;
        n_opa      = r_opa;
        n_acc      = r_acc;
        n_rem      = r_rem;
        n_pverdict = r_pverdict;
        n_pwait    = r_pwait;
        n_ov       = r_ov && !i_ready;
        n_overdict = r_overdict;
        n_owait    = r_owait;
        n_orun     = r_orun;
        unique case (r_state)
            rtbl_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_new_connection) begin
                        n_level = cap;
                        n_run   = '0;
                    end
                    n_opa      = i_elapsed_ticks;
                    n_acc      = '0;
                    n_cnt      = 5'd31;
                    n_pverdict = rtbl_pkg::VERDICT_GRANT;
                    n_pwait    = '0;
                    n_state    = r_en ? rtbl_pkg::S_MUL : rtbl_pkg::S_DONE;
                end
            end
            rtbl_pkg::S_MUL: begin
                n_acc = (add_sum[33:32] != 2'd0) ? 33'h1_0000_0000 : {1'b0, add_sum[31:0]};
                n_opa = {r_opa[30:0], 1'b0};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_state = rtbl_pkg::S_CHECK;
                end
            end
            rtbl_pkg::S_CHECK: begin
                if (lvl >= rtbl_pkg::ONE_TOKEN) begin
                    n_level = lvl - rtbl_pkg::ONE_TOKEN;
                    n_run   = '0;
                    n_state = rtbl_pkg::S_DONE;
                end else begin
                    n_level = lvl;
                    n_run   = run_inc;
                    if (run_inc > {1'b0, r_disc}) begin
                        n_pverdict = rtbl_pkg::VERDICT_DISCONNECT;
                        n_state    = rtbl_pkg::S_DONE;
                    end else begin
                        n_opa   = {15'd0, 17'h1_0000 - lvl[16:0]};
                        n_rem   = '0;
                        n_cnt   = 5'd16;
                        n_state = rtbl_pkg::S_DIV;
                    end
                end
            end
            rtbl_pkg::S_DIV: begin
                n_rem = add_sum[34] ? add_sum[23:0] : add_a[23:0];
                n_opa = {15'd0, r_opa[15:0], add_sum[34]};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_state = rtbl_pkg::S_FIN;
                end
            end
            rtbl_pkg::S_FIN: begin
                n_pwait    = {15'd0, r_opa[16:0]} + {31'd0, (r_rem != 24'd0)};
                n_pverdict = rtbl_pkg::VERDICT_GRANT_WAIT;
                n_level    = fin_lvl;
                n_state    = rtbl_pkg::S_DONE;
            end
            rtbl_pkg::S_DONE: begin
                if (!r_ov || i_ready) begin
                    n_ov       = 1'b1;
                    n_overdict = r_pverdict;
                    n_owait    = r_pwait;
                    n_orun     = r_run;
                    n_state    = rtbl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rtbl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rtbl_pkg::S_IDLE;
            r_ov    <= 1'b0;
            r_level <= '0;
            r_run   <= '0;
            r_en    <= 1'b0;
            r_rate  <= 24'h01_0000;
            r_burst <= 16'd1;
            r_disc  <= 16'd0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_level <= n_level;
            r_run   <= n_run;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rtbl_pkg::REG_LIMIT_ENABLE:     r_en    <= i_cfg_data[0];
                    rtbl_pkg::REG_RATE_PER_TICK:    r_rate  <= i_cfg_data;
                    rtbl_pkg::REG_BURST_TOKENS:     r_burst <= i_cfg_data[15:0];
                    rtbl_pkg::REG_DISCONNECT_AFTER: r_disc  <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_opa      <= n_opa;
        r_acc      <= n_acc;
        r_rem      <= n_rem;
        r_pverdict <= n_pverdict;
        r_pwait    <= n_pwait;
        r_overdict <= n_overdict;
        r_owait    <= n_owait;
        r_orun     <= n_orun;
    end

`ifndef SYNTHESIS
    a_wait_only_delayed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_verdict != rtbl_pkg::VERDICT_GRANT_WAIT)) |-> (o_wait_ticks == 32'd0))
        else $error("wait reported without delayed grant");

    a_wait_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_verdict == rtbl_pkg::VERDICT_GRANT_WAIT))
            |-> ((o_wait_ticks != 32'd0) && (o_wait_ticks <= 32'h0001_0000)))
        else $error("delayed grant wait out of range");

    a_disc_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_verdict == rtbl_pkg::VERDICT_DISCONNECT)) |-> (o_delay_run != 17'd0))
        else $error("disconnect with empty delay run");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input ready right after a transfer");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_verdict != 2'd3))
        else $error("reserved verdict code");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for the request token bucket limiter: directed table, then random phases.
module tb_top;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned RAND_PHASES  = 10;
    localparam int unsigned PHASE_ITEMS  = 55;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned HOLD_AT      = 150;
    localparam int unsigned TAIL_CYCLES  = 60;

    typedef logic [rtbl_pkg::TicksW-1:0]   t_ticks;
    typedef logic [rtbl_pkg::CfgDataW-1:0] t_cfg_data;

    typedef struct packed {
        logic [1:0]                  verdict;
        logic [rtbl_pkg::TicksW-1:0] wait_ticks;
        logic [rtbl_pkg::RunW-1:0]   delay_run;
    } t_police_rec;

    typedef struct {
        logic                          is_cfg;
        logic [rtbl_pkg::CfgIdxW-1:0]  idx;
        logic [rtbl_pkg::CfgDataW-1:0] data;
        logic [rtbl_pkg::TicksW-1:0]   elapsed;
        logic                          new_conn;
        logic                          typed;
        t_police_rec                   want;
    } t_stim_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic [rtbl_pkg::TicksW-1:0]   i_elapsed_ticks = '0;
    logic                          i_new_connection = 1'b0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [1:0]                    o_verdict;
    logic [rtbl_pkg::TicksW-1:0]   o_wait_ticks;
    logic [rtbl_pkg::RunW-1:0]     o_delay_run;
    logic                          i_cfg_we = 1'b0;
    logic [rtbl_pkg::CfgIdxW-1:0]  i_cfg_index = '0;
    logic [rtbl_pkg::CfgDataW-1:0] i_cfg_data = '0;

    logic                          pol_enable;
    logic [rtbl_pkg::RateW-1:0]    pol_rate;
    logic [rtbl_pkg::BurstW-1:0]   pol_burst;
    logic [rtbl_pkg::BurstW-1:0]   pol_disc;
    logic [rtbl_pkg::LevelW-1:0]   bucket_level;
    logic [rtbl_pkg::RunW-1:0]     delay_count;

    t_police_rec pending_verdicts[$];
    t_stim_row   stim_table[$];

    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned grants_now = 0;
    int unsigned grants_late = 0;
    int unsigned disconnects = 0;
    int unsigned reg_writes = 0;
    bit          calm = 1'b0;

    request_token_bucket_limiter u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_elapsed_ticks  (i_elapsed_ticks),
        .i_new_connection (i_new_connection),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_verdict        (o_verdict),
        .o_wait_ticks     (o_wait_ticks),
        .o_delay_run      (o_delay_run),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic [63:0] eff_rate();
        return (pol_rate == '0) ? 64'd1 : {40'b0, pol_rate};
    endfunction

    function automatic logic [63:0] bucket_cap();
        return {32'b0, (pol_burst == '0) ? 16'd1 : pol_burst, 16'b0};
    endfunction

    function automatic logic [rtbl_pkg::LevelW-1:0] refill(
        input logic [rtbl_pkg::LevelW-1:0] lvl, input logic [63:0] ticks);
        logic [63:0] sum;
        logic [63:0] cap;
        cap = bucket_cap();
        sum = {32'b0, lvl} + ticks * eff_rate();
        return (sum > cap) ? cap[rtbl_pkg::LevelW-1:0] : sum[rtbl_pkg::LevelW-1:0];
    endfunction

    function automatic t_police_rec police_request(input logic [rtbl_pkg::TicksW-1:0] elapsed,
                                                   input logic new_conn);
        t_police_rec res;
        logic [63:0] deficit;
        logic [63:0] rate;
        logic [63:0] hold_ticks;
        logic [63:0] cap;
        res = '0;
        res.verdict = rtbl_pkg::VERDICT_GRANT;
        cap = bucket_cap();
        if (new_conn) begin
            bucket_level = cap[rtbl_pkg::LevelW-1:0];
            delay_count  = '0;
        end
        if (pol_enable) begin
            bucket_level = refill(bucket_level, {32'b0, elapsed});
            if (bucket_level >= rtbl_pkg::ONE_TOKEN) begin
                bucket_level = bucket_level - rtbl_pkg::ONE_TOKEN;
                delay_count  = '0;
            end else begin
                if (delay_count < rtbl_pkg::RUN_MAX) delay_count = delay_count + 17'd1;
                if ({15'b0, delay_count} > {16'b0, pol_disc}) begin
                    res.verdict = rtbl_pkg::VERDICT_DISCONNECT;
                end else begin
                    rate         = eff_rate();
                    deficit      = 64'(rtbl_pkg::ONE_TOKEN) - {32'b0, bucket_level};
                    hold_ticks   = (deficit + rate - 64'd1) / rate;
                    bucket_level = refill(bucket_level, hold_ticks);
                    bucket_level = bucket_level - rtbl_pkg::ONE_TOKEN;
                    res.verdict    = rtbl_pkg::VERDICT_GRANT_WAIT;
                    res.wait_ticks = hold_ticks[rtbl_pkg::TicksW-1:0];
                end
            end
        end
        res.delay_run = delay_count;
        return res;
    endfunction

    function automatic void add_cfg(input logic [rtbl_pkg::CfgIdxW-1:0] idx,
                                    input logic [rtbl_pkg::CfgDataW-1:0] data);
        t_stim_row row;
        row = '{is_cfg: 1'b1, idx: idx, data: data, elapsed: '0, new_conn: 1'b0,
                typed: 1'b0, want: '0};
        stim_table.insert(stim_table.size(), row);
    endfunction

    function automatic void add_req(input logic [rtbl_pkg::TicksW-1:0] elapsed,
                                    input logic new_conn);
        t_stim_row row;
        row = '{is_cfg: 1'b0, idx: '0, data: '0, elapsed: elapsed, new_conn: new_conn,
                typed: 1'b0, want: '0};
        stim_table.insert(stim_table.size(), row);
    endfunction

    function automatic void add_req_exp(input logic [rtbl_pkg::TicksW-1:0] elapsed,
                                        input logic new_conn,
                                        input logic [1:0] verdict,
                                        input logic [rtbl_pkg::TicksW-1:0] wait_ticks,
                                        input logic [rtbl_pkg::RunW-1:0] delay_run);
        t_stim_row row;
        row = '{is_cfg: 1'b0, idx: '0, data: '0, elapsed: elapsed, new_conn: new_conn,
                typed: 1'b1, want: '{verdict, wait_ticks, delay_run}};
        stim_table.insert(stim_table.size(), row);
    endfunction

    task automatic write_reg(input logic [rtbl_pkg::CfgIdxW-1:0] idx,
                             input logic [rtbl_pkg::CfgDataW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            rtbl_pkg::REG_LIMIT_ENABLE:     pol_enable = data[0];
            rtbl_pkg::REG_RATE_PER_TICK:    pol_rate   = data[rtbl_pkg::RateW-1:0];
            rtbl_pkg::REG_BURST_TOKENS:     pol_burst  = data[rtbl_pkg::BurstW-1:0];
            rtbl_pkg::REG_DISCONNECT_AFTER: pol_disc   = data[rtbl_pkg::BurstW-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic send_request(input logic [rtbl_pkg::TicksW-1:0] elapsed,
                                input logic new_conn,
                                input logic typed, input t_police_rec want);
        t_police_rec pred;
        while (!calm && $urandom_range(99) < 7) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_elapsed_ticks  <= elapsed;
        i_new_connection <= new_conn;
        do @(posedge i_clk); while (!o_ready);
        pred = police_request(elapsed, new_conn);
        pending_verdicts.insert(pending_verdicts.size(), typed ? want : pred);
        @(negedge i_clk);
    endtask

    function automatic logic [rtbl_pkg::TicksW-1:0] pick_elapsed();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 40) return t_ticks'($urandom_range(3));
        if (roll < 70) return t_ticks'($urandom_range(70000));
        if (roll < 90) return t_ticks'($urandom);
        return ($urandom_range(1) != 0) ? '1 : '0;
    endfunction

    initial begin : sink
        bit held;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= HOLD_AT) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_ready <= calm || ($urandom_range(99) >= 7);
            end
        end
    end

    always @(posedge i_clk) begin
        t_police_rec want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result: verdict %0d wait_ticks %0d delay_run %0d",
                       o_verdict, o_wait_ticks, o_delay_run);
                mismatches++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_verdict !== want.verdict) begin
                    $error("verdict: expected %0d, actual %0d", want.verdict, o_verdict);
                    mismatches++;
                end
                if (o_wait_ticks !== want.wait_ticks) begin
                    $error("wait_ticks: expected %0d, actual %0d", want.wait_ticks,
                           o_wait_ticks);
                    mismatches++;
                end
                if (o_delay_run !== want.delay_run) begin
                    $error("delay_run: expected %0d, actual %0d", want.delay_run,
                           o_delay_run);
                    mismatches++;
                end
                case (want.verdict)
                    rtbl_pkg::VERDICT_GRANT:      grants_now++;
                    rtbl_pkg::VERDICT_GRANT_WAIT: grants_late++;
                    default:                      disconnects++;
                endcase
            end
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int unsigned phase;
        int unsigned n;
        logic [rtbl_pkg::CfgDataW-1:0] rate_v;
        logic [rtbl_pkg::CfgDataW-1:0] burst_v;
        logic [rtbl_pkg::CfgDataW-1:0] disc_v;
        pol_enable   = 1'b0;
        pol_rate     = 24'd65536;
        pol_burst    = 16'd1;
        pol_disc     = 16'd0;
        bucket_level = '0;
        delay_count  = '0;

        add_req_exp(32'd0, 1'b0, rtbl_pkg::VERDICT_GRANT, 32'd0, 17'd0);
        add_req_exp(32'hFFFF_FFFF, 1'b1, rtbl_pkg::VERDICT_GRANT, 32'd0, 17'd0);
        add_req(32'h5555_5555, 1'b0);
        add_cfg(rtbl_pkg::REG_LIMIT_ENABLE, 24'd1);
        add_req_exp(32'd0, 1'b0, rtbl_pkg::VERDICT_GRANT, 32'd0, 17'd0);
        add_req_exp(32'd0, 1'b0, rtbl_pkg::VERDICT_DISCONNECT, 32'd0, 17'd1);
        add_req_exp(32'd0, 1'b0, rtbl_pkg::VERDICT_DISCONNECT, 32'd0, 17'd2);
        add_cfg(rtbl_pkg::REG_DISCONNECT_AFTER, 24'hFFFF);
        add_req_exp(32'd0, 1'b0, rtbl_pkg::VERDICT_GRANT_WAIT, 32'd1, 17'd3);
        add_req_exp(32'd1, 1'b0, rtbl_pkg::VERDICT_GRANT, 32'd0, 17'd0);
        add_cfg(rtbl_pkg::REG_RATE_PER_TICK, 24'd0);
        add_req_exp(32'd0, 1'b1, rtbl_pkg::VERDICT_GRANT, 32'd0, 17'd0);
        add_req_exp(32'd0, 1'b0, rtbl_pkg::VERDICT_GRANT_WAIT, 32'd65536, 17'd1);
        add_req_exp(32'd40000, 1'b0, rtbl_pkg::VERDICT_GRANT_WAIT, 32'd25536, 17'd2);
        add_cfg(rtbl_pkg::REG_RATE_PER_TICK, 24'hFF_FFFF);
        add_cfg(rtbl_pkg::REG_BURST_TOKENS, 24'd0);
        add_req_exp(32'hFFFF_FFFF, 1'b0, rtbl_pkg::VERDICT_GRANT, 32'd0, 17'd0);
        add_req_exp(32'd0, 1'b0, rtbl_pkg::VERDICT_GRANT_WAIT, 32'd1, 17'd1);
        add_cfg(rtbl_pkg::REG_BURST_TOKENS, 24'hFFFF);
        add_req_exp(32'hFFFF_FFFF, 1'b0, rtbl_pkg::VERDICT_GRANT, 32'd0, 17'd0);
        add_req(32'd0, 1'b1);
        add_cfg(rtbl_pkg::REG_RATE_PER_TICK, 24'd3);
        add_cfg(rtbl_pkg::REG_BURST_TOKENS, 24'd2);
        add_cfg(rtbl_pkg::REG_DISCONNECT_AFTER, 24'd2);
        add_req(32'd0, 1'b1);
        add_req(32'd0, 1'b0);
        add_req(32'd0, 1'b0);
        add_req(32'd5, 1'b0);
        add_req(32'd0, 1'b0);
        add_req(32'd7, 1'b1);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_table[k]) begin
            if (stim_table[k].is_cfg) begin
                drain();
                write_reg(stim_table[k].idx, stim_table[k].data);
            end else begin
                send_request(stim_table[k].elapsed, stim_table[k].new_conn,
                             stim_table[k].typed, stim_table[k].want);
            end
        end

        for (phase = 0; phase < RAND_PHASES; phase++) begin
            drain();
            case ($urandom_range(5))
                0:       rate_v = 24'd0;
                1:       rate_v = 24'd1;
                2:       rate_v = 24'hFF_FFFF;
                3:       rate_v = 24'd65536;
                4:       rate_v = t_cfg_data'($urandom_range(1, 200000));
                default: rate_v = t_cfg_data'($urandom);
            endcase
            case ($urandom_range(3))
                0:       burst_v = 24'd0;
                1:       burst_v = 24'd1;
                2:       burst_v = 24'hFFFF;
                default: burst_v = t_cfg_data'($urandom_range(2, 8));
            endcase
            case ($urandom_range(3))
                0:       disc_v = 24'd0;
                1:       disc_v = 24'hFFFF;
                default: disc_v = t_cfg_data'($urandom_range(1, 6));
            endcase
            write_reg(rtbl_pkg::REG_LIMIT_ENABLE, (phase == 3) ? 24'd0 : 24'd1);
            write_reg(rtbl_pkg::REG_RATE_PER_TICK, rate_v);
            write_reg(rtbl_pkg::REG_BURST_TOKENS, burst_v);
            write_reg(rtbl_pkg::REG_DISCONNECT_AFTER, disc_v);
            calm = (phase == 5);
            send_request(pick_elapsed(), 1'b1, 1'b0, '0);
            for (n = 1; n < PHASE_ITEMS; n++) begin
                send_request(pick_elapsed(), $urandom_range(99) < 5, 1'b0, '0);
            end
            calm = 1'b0;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_verdicts.size() != 0) begin
            $error("%0d expected results never arrived", pending_verdicts.size());
            mismatches++;
        end
        $display("Checked %0d results: %0d immediate grants, %0d delayed grants, %0d disconnects",
                 results_seen, grants_now, grants_late, disconnects);
        $display("Register writes: %0d over %0d random phases, one long output stall",
                 reg_writes, RAND_PHASES);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
